[hdl/ps2md_pkg.sv]
// Shared constants and types for the PS/2 mouse packet decoder.
package ps2md_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(1024);
    localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(768);
    localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'(512);
    localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'(384);

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_X = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_Y = CFG_INDEX_BITS'(1);

    localparam logic [7:0] RESYNC_LEAD = 8'h0C;
    localparam logic [7:0] RESYNC_ZERO = 8'h00;

    localparam int BIT_LEFT = 0;
    localparam int BIT_RIGHT = 1;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;

    typedef enum logic [1:0] {
        SLOT_HEADER = 2'd0,
        SLOT_X      = 2'd1,
        SLOT_Y      = 2'd2,
        SLOT_DONE   = 2'd3
    } slot_t;

    typedef enum logic [1:0] {
        RS_IDLE = 2'd0,
        RS_C    = 2'd1,
        RS_C0   = 2'd2
    } resync_t;

endpackage

[hdl/ps2_mouse_packet_decoder.sv]
// Top level of the PS/2 mouse packet decoder.
//
// Input channel: one mouse byte per transfer on rx_byte (in_valid / in_stall).
// Bytes are framed in threes: header (buttons, sign bits), X delta, Y delta.
// Output channel: after the third byte of a frame one transfer carries the
// clamped cursor position and the press and release edges of both buttons.
// The sequence 0x0C 0x00 0x00 restarts framing and produces no transfer.
// Config channel: cfg_index 0 writes max_x, 1 writes max_y; other indexes
// are ignored. cfg_ready is always high; write only while the block is idle.
// Latency: a result is valid the cycle after its third byte is accepted.
// Throughput: one byte per cycle, set by the single output register; a byte
// is accepted whenever that register is empty or being taken in that cycle.
// When the receiver stalls with a result pending, in_stall rises and the
// result holds until taken.
// Reset: max_x 1024, max_y 768, cursor at 512/384, buttons released,
// framing at the header byte, no result pending.
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COORD_BITS-1:0]     pos_x,
    output logic [COORD_BITS-1:0]     pos_y,
    output logic                      left_press,
    output logic                      left_release,
    output logic                      right_press,
    output logic                      right_release,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data
);

    logic [COORD_BITS-1:0] max_x_reg;
    logic [COORD_BITS-1:0] max_y_reg;
    slot_t                 slot_reg, slot_next;
    resync_t               resync_reg, resync_next;
    logic                  left_now_reg, right_now_reg;
    logic                  x_neg_reg, y_neg_reg;
    logic                  left_held_reg, right_held_reg;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic                  lp_reg, lr_reg, rp_reg, rr_reg;

    logic                  in_accept;
    logic                  matched;
    logic                  emit;
    logic                  lp, lr, rp, rr;
    logic [COORD_BITS-1:0] step_x, step_y;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    ps2md_axis u_axis_x (
        .cur        (cursor_x_reg),
        .delta_lo   (rx_byte),
        .delta_neg  (x_neg_reg),
        .subtract   (1'b0),
        .max_coord  (max_x_reg),
        .next_coord (step_x)
    );

    ps2md_axis u_axis_y (
        .cur        (cursor_y_reg),
        .delta_lo   (rx_byte),
        .delta_neg  (y_neg_reg),
        .subtract   (1'b1),
        .max_coord  (max_y_reg),
        .next_coord (step_y)
    );

    assign matched = (resync_reg == RS_C0) && (rx_byte == RESYNC_ZERO);
    assign emit    = (slot_reg == SLOT_Y) && !matched;

    always_comb
    begin
        if (resync_reg == RS_C && rx_byte == RESYNC_ZERO)
            resync_next = RS_C0;
        else if (matched)
            resync_next = RS_IDLE;
        else if (rx_byte == RESYNC_LEAD)
            resync_next = RS_C;
        else
            resync_next = RS_IDLE;

        unique case (slot_reg)
            SLOT_HEADER: slot_next = SLOT_X;
            SLOT_X:      slot_next = SLOT_Y;
            default:     slot_next = SLOT_HEADER;
        endcase
        if (matched)
            slot_next = SLOT_HEADER;

        cursor_x_next = (slot_reg == SLOT_X) ? step_x : cursor_x_reg;
        cursor_y_next = (slot_reg == SLOT_Y) ? step_y : cursor_y_reg;

        lp = !left_held_reg && left_now_reg;
        lr = left_held_reg && !left_now_reg;
        rp = !right_held_reg && right_now_reg;
        rr = right_held_reg && !right_now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg      <= MAX_X_RESET;
            max_y_reg      <= MAX_Y_RESET;
            slot_reg       <= SLOT_HEADER;
            resync_reg     <= RS_IDLE;
            left_now_reg   <= 1'b0;
            right_now_reg  <= 1'b0;
            x_neg_reg      <= 1'b0;
            y_neg_reg      <= 1'b0;
            left_held_reg  <= 1'b0;
            right_held_reg <= 1'b0;
            cursor_x_reg   <= CURSOR_X_RESET;
            cursor_y_reg   <= CURSOR_Y_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_X)
                    max_x_reg <= cfg_data;
                else if (cfg_index == REG_MAX_Y)
                    max_y_reg <= cfg_data;
            end

            if (in_accept)
            begin
                slot_reg     <= slot_next;
                resync_reg   <= resync_next;
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
                if (slot_reg == SLOT_HEADER)
                begin
                    left_now_reg  <= rx_byte[BIT_LEFT];
                    right_now_reg <= rx_byte[BIT_RIGHT];
                    x_neg_reg     <= rx_byte[BIT_X_SIGN];
                    y_neg_reg     <= rx_byte[BIT_Y_SIGN];
                end
                if (emit)
                begin
                    left_held_reg  <= left_now_reg;
                    right_held_reg <= right_now_reg;
                end
            end

            if (in_accept && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            pos_x_reg <= cursor_x_next;
            pos_y_reg <= cursor_y_next;
            lp_reg    <= lp;
            lr_reg    <= lr;
            rp_reg    <= rp;
            rr_reg    <= rr;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign left_press    = lp_reg;
    assign left_release  = lr_reg;
    assign right_press   = rp_reg;
    assign right_release = rr_reg;

`ifndef SYNTH
    a_emit_after_y: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit) |=> out_valid_reg)
        else $error("third byte accepted without result");

    a_resync_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && matched) |=> (slot_reg == SLOT_HEADER && resync_reg == RS_IDLE))
        else $error("resync match did not restart framing");

    a_edge_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !((lp_reg && lr_reg) || (rp_reg && rr_reg)))
        else $error("press and release of one button in one result");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !in_accept) |=> !out_valid_reg)
        else $error("result repeated after transfer");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> slot_reg != SLOT_DONE)
        else $error("frame slot overran");
`endif

endmodule

[hdl/ps2md_axis.sv]
// One cursor axis: adds or subtracts a 9-bit signed delta and clamps to 0..max.
module ps2md_axis
    import ps2md_pkg::*;
(
    input  logic [COORD_BITS-1:0] cur,
    input  logic [7:0]            delta_lo,
    input  logic                  delta_neg,
    input  logic                  subtract,
    input  logic [COORD_BITS-1:0] max_coord,
    output logic [COORD_BITS-1:0] next_coord
);

    logic signed [COORD_BITS+1:0] cur_ext;
    logic signed [COORD_BITS+1:0] delta_ext;
    logic signed [COORD_BITS+1:0] max_ext;
    logic signed [COORD_BITS+1:0] sum;

    assign cur_ext = $signed({2'b00, cur});
    assign max_ext = $signed({2'b00, max_coord});
    assign delta_ext = $signed({{(COORD_BITS-6){delta_neg}}, delta_lo});
    assign sum = subtract ? (cur_ext - delta_ext) : (cur_ext + delta_ext);

    always_comb
    begin
        if (sum < 0)
            next_coord = '0;
        else if (sum > max_ext)
            next_coord = max_coord;
        else
            next_coord = sum[COORD_BITS-1:0];
    end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the PS/2 mouse packet decoder: directed and random byte streams.
module tb;
    import ps2md_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int BYTES_PER_PHASE = 140;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = CFG_INDEX_BITS'(3);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  lp;
        logic                  lr;
        logic                  rp;
        logic                  rr;
    } mouse_report_t;

    class pointer_tracker;
        logic [COORD_BITS-1:0] lim_x;
        logic [COORD_BITS-1:0] lim_y;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        slot_t                 expecting;
        resync_t               hunt;
        logic                  left_now;
        logic                  right_now;
        logic                  x_neg;
        logic                  y_neg;
        logic                  left_held;
        logic                  right_held;
        mouse_report_t         due[$];
        int                    mismatches;

        function new();
            lim_x = MAX_X_RESET;
            lim_y = MAX_Y_RESET;
            cur_x = CURSOR_X_RESET;
            cur_y = CURSOR_Y_RESET;
            expecting = SLOT_HEADER;
            hunt = RS_IDLE;
            left_now = 1'b0;
            right_now = 1'b0;
            x_neg = 1'b0;
            y_neg = 1'b0;
            left_held = 1'b0;
            right_held = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
            if (idx == REG_MAX_X)
                lim_x = data;
            else if (idx == REG_MAX_Y)
                lim_y = data;
        endfunction

        function logic [COORD_BITS-1:0] clamp(int v, logic [COORD_BITS-1:0] lim);
            if (v > int'(lim))
                v = int'(lim);
            if (v < 0)
                v = 0;
            return v[COORD_BITS-1:0];
        endfunction

        function void take_byte(logic [7:0] b);
            logic                matched;
            logic signed [8:0]   delta;
            mouse_report_t       r;
            matched = 1'b0;
            if (hunt == RS_C && b == RESYNC_ZERO)
                hunt = RS_C0;
            else if (hunt == RS_C0 && b == RESYNC_ZERO)
                matched = 1'b1;
            else if (b == RESYNC_LEAD)
                hunt = RS_C;
            else
                hunt = RS_IDLE;

            case (expecting)
                SLOT_HEADER:
                begin
                    left_now = b[BIT_LEFT];
                    right_now = b[BIT_RIGHT];
                    x_neg = b[BIT_X_SIGN];
                    y_neg = b[BIT_Y_SIGN];
                end
                SLOT_X:
                begin
                    delta = {x_neg, b};
                    cur_x = clamp(int'(cur_x) + int'(delta), lim_x);
                end
                SLOT_Y:
                begin
                    delta = {y_neg, b};
                    cur_y = clamp(int'(cur_y) - int'(delta), lim_y);
                end
                default:
                begin
                end
            endcase

            // resync: deltas already applied, framing restarts, no transfer
            if (matched)
            begin
                expecting = SLOT_HEADER;
                hunt = RS_IDLE;
                return;
            end
            if (expecting != SLOT_Y)
            begin
                expecting = slot_t'(expecting + 1);
                return;
            end
            expecting = SLOT_HEADER;

            r = '0;
            r.x = cur_x;
            r.y = cur_y;
            if (!left_held && left_now)
            begin
                left_held = 1'b1;
                r.lp = 1'b1;
            end
            else if (left_held && !left_now)
            begin
                left_held = 1'b0;
                r.lr = 1'b1;
            end
            if (!right_held && right_now)
            begin
                right_held = 1'b1;
                r.rp = 1'b1;
            end
            else if (right_held && !right_now)
            begin
                right_held = 1'b0;
                r.rr = 1'b1;
            end
            due.push_back(r);
        endfunction

        function void compare(string what, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_report(mouse_report_t got);
            mouse_report_t exp_r;
            if (due.size() == 0)
            begin
                $display("%0t: transfer with nothing expected, x %0d y %0d", $time, got.x, got.y);
                mismatches++;
                return;
            end
            exp_r = due.pop_front();
            compare("pos_x", exp_r.x, got.x);
            compare("pos_y", exp_r.y, got.y);
            compare("left_press", exp_r.lp, got.lp);
            compare("left_release", exp_r.lr, got.lr);
            compare("right_press", exp_r.rp, got.rp);
            compare("right_release", exp_r.rr, got.rr);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                rx_byte = 8'h00;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [COORD_BITS-1:0]     pos_x;
    logic [COORD_BITS-1:0]     pos_y;
    logic                      left_press;
    logic                      left_release;
    logic                      right_press;
    logic                      right_release;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]     cfg_data = '0;

    int             src_idle_pct = 0;
    int             sink_stall_pct = 0;
    int             cycles = 0;
    pointer_tracker trk = new();

    ps2_mouse_packet_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .left_press    (left_press),
        .left_release  (left_release),
        .right_press   (right_press),
        .right_release (right_release),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checked before the byte of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                trk.check_report({pos_x, pos_y, left_press, left_release,
                                  right_press, right_release});
            if (in_valid && !in_stall)
                trk.take_byte(rx_byte);
            if (cfg_valid && cfg_ready)
                trk.write_reg(cfg_index, cfg_data);
        end
    end

    always @(negedge clk)
        out_stall = ($urandom_range(99) < sink_stall_pct);

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            rx_byte = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (trk.due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [7:0]            opening[$];
        int                    sent;
        int                    pick;
        logic [COORD_BITS-1:0] lx;
        logic [COORD_BITS-1:0] ly;

        // press both, full +X; release both, -256 X; all bits set;
        // bare resync; resync landing on a header; then edges again
        opening = '{8'h03, 8'hFF, 8'h00,
                    8'h30, 8'h00, 8'h01,
                    8'hFF, 8'hFF, 8'hFF,
                    RESYNC_LEAD, RESYNC_ZERO, RESYNC_ZERO,
                    8'h08, RESYNC_LEAD, RESYNC_ZERO, RESYNC_ZERO,
                    8'h21, 8'h80, 8'h7F,
                    8'h02, 8'h01, 8'h80};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening[k])
            send_byte(opening[k]);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                case (ph)
                    1: begin lx = 12'd4095; ly = 12'd4095; end
                    2: begin lx = 12'd1;    ly = 12'd1;    end
                    3: begin lx = 12'd0;    ly = 12'd4095; end
                    4: begin lx = 12'd4095; ly = 12'd0;    end
                    6: begin lx = 12'd100;  ly = 12'd3000; end
                    default:
                    begin
                        lx = 12'($urandom);
                        ly = 12'($urandom);
                    end
                endcase
                cfg_write(REG_MAX_X, lx);
                cfg_write(REG_MAX_Y, ly);
                cfg_write(REG_SPARE_A, 12'($urandom));
                cfg_write(REG_SPARE_B, 12'($urandom));
            end

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 19; sink_stall_pct = 19; end
            endcase

            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 4)
                begin
                    send_byte(RESYNC_LEAD);
                    send_byte(RESYNC_ZERO);
                    send_byte(RESYNC_ZERO);
                    sent += 3;
                end
                else if (pick < 9)
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
                else
                begin
                    send_byte(8'($urandom));
                    send_byte(pick_delta());
                    send_byte(pick_delta());
                    sent += 3;
                end
                if ($urandom_range(99) == 0)
                    wait_idle();
            end
        end

        in_valid = 1'b0;
        while (trk.due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (trk.mismatches == 0 && trk.due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hdl/ps2md_pkg.sv
hdl/ps2md_axis.sv
hdl/ps2_mouse_packet_decoder.sv
tb/sv/tb.sv
